// ===== src/pnpt_pkg.sv =====
`timescale 1ns / 1ps

package pnpt_pkg;

    localparam int ADDR_W = 16;

    localparam logic [1:0] MODE_TIME   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [2:0] REG_START_TIME  = 3'd0;
    localparam logic [2:0] REG_END_TIME    = 3'd1;
    localparam logic [2:0] REG_THR_ENABLE  = 3'd2;
    localparam logic [2:0] REG_THRESHOLD   = 3'd3;
    localparam logic [2:0] REG_EXPONENT    = 3'd4;
    localparam logic [2:0] REG_NODE_COUNT  = 3'd5;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] start_time;
        logic signed [31:0] end_time;
        logic               thr_enable;
        logic signed [31:0] threshold;
        logic [2:0]         exponent;
        logic [10:0]        node_count;
    } cfg_t;

    // span is the frame step for samples and the window length for reads
    typedef struct packed {
        logic               is_read;
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] sample;
        logic               integ;
        logic signed [32:0] span;
        logic               node_ok;
        logic               mean_ok;
        logic [9:0]         node;
    } cmd_t;

endpackage

// ===== src/per_node_peak_and_time_integral.sv =====
`timescale 1ns / 1ps

// per-node peak, window mean and thresholded excess integral over frames of node
// samples. a front end takes a transaction when the queue has room and the stores
// are cleared, tracks frame time and the window, and passes sample and read work
// through a two-entry queue to a back end that does a read-modify-write of the node
// stores. after reset the back end sweeps the stores to their reset values, taking
// no input transactions meanwhile (configuration writes are always taken). an
// integrating sample forms its area term, and above an enabled threshold the powers
// of the excess and their product with the frame step, on the shared 4-stage
// multiplier; a read forms the mean with the 64-step divider when the window is open.
module per_node_peak_and_time_integral #(
    parameter int NODES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_frame_time,
    input  logic signed [31:0] s_sample_value,
    input  logic [9:0]         s_read_node,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_node,
    output logic signed [31:0] m_peak,
    output logic signed [31:0] m_mean,
    output logic signed [63:0] m_excess,
    output logic               m_mean_invalid
);

    logic signed [31:0] start_time_reg;
    logic signed [31:0] end_time_reg;
    logic               thr_enable_reg;
    logic signed [31:0] threshold_reg;
    logic [2:0]         exponent_reg;
    logic [10:0]        node_count_reg;

    pnpt_pkg::cfg_t cfg;
    pnpt_pkg::cmd_t q_in, q_out;
    logic q_push, q_full, q_pop, q_empty;
    logic init_done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_time_reg <= pnpt_pkg::S32_MIN;
            end_time_reg   <= pnpt_pkg::S32_MAX;
            thr_enable_reg <= 1'b0;
            threshold_reg  <= pnpt_pkg::S32_MIN;
            exponent_reg   <= 3'd1;
            node_count_reg <= 11'd1024;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pnpt_pkg::REG_START_TIME: start_time_reg <= cfg_data;
                pnpt_pkg::REG_END_TIME:   end_time_reg   <= cfg_data;
                pnpt_pkg::REG_THR_ENABLE: thr_enable_reg <= cfg_data[0];
                pnpt_pkg::REG_THRESHOLD:  threshold_reg  <= cfg_data;
                pnpt_pkg::REG_EXPONENT:   exponent_reg   <= cfg_data[2:0];
                pnpt_pkg::REG_NODE_COUNT: node_count_reg <= cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.start_time = start_time_reg;
        cfg.end_time   = end_time_reg;
        cfg.thr_enable = thr_enable_reg;
        cfg.threshold  = threshold_reg;
        cfg.exponent   = exponent_reg;
        cfg.node_count = node_count_reg;
    end

    pnpt_front #(
        .NODES (NODES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .enable         (init_done),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_frame_time   (s_frame_time),
        .s_sample_value (s_sample_value),
        .s_read_node    (s_read_node),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    pnpt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    pnpt_back #(
        .NODES (NODES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd_valid      (!q_empty),
        .cmd            (q_out),
        .cmd_pop        (q_pop),
        .init_done      (init_done),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_node         (m_node),
        .m_peak         (m_peak),
        .m_mean         (m_mean),
        .m_excess       (m_excess),
        .m_mean_invalid (m_mean_invalid)
    );

    a_no_input_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_ready)
        else $error("input taken during store clearing");

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("queue overflow");

    a_queue_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_empty))
        else $error("queue underflow");

    a_invalid_mean_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_mean_invalid) |-> (m_mean == 32'sd0))
        else $error("invalid mean not zero");

endmodule

// ===== src/pnpt_fifo.sv =====
`timescale 1ns / 1ps

module pnpt_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pnpt_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output pnpt_pkg::cmd_t  pop_data,
    output logic            empty
);

    pnpt_pkg::cmd_t ent_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = ent_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_data;
        end
    end

endmodule

// ===== src/pnpt_front.sv =====
`timescale 1ns / 1ps

module pnpt_front #(
    parameter int NODES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pnpt_pkg::cfg_t     cfg,
    input  logic               enable,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic signed [31:0] s_frame_time,
    input  logic signed [31:0] s_sample_value,
    input  logic [9:0]         s_read_node,
    input  logic               q_full,
    output logic               q_push,
    output pnpt_pkg::cmd_t     q_data
);

    localparam int MW = pnpt_pkg::ADDR_W;

    logic signed [31:0] cur_t_reg, cur_t_next;
    logic signed [31:0] prior_t_reg, prior_t_next;
    logic signed [31:0] first_t_reg, first_t_next;
    logic               open_reg, open_next;
    logic               seen_reg, seen_next;
    logic               integ_reg, integ_next;
    logic               stopped_reg, stopped_next;
    logic [10:0]        cnt_reg, cnt_next;
    logic               below;
    logic signed [32:0] win_len;

    assign s_ready = enable && !q_full;
    assign below   = (cnt_reg < cfg.node_count) && (int'(cnt_reg) < NODES);
    assign win_len = 33'(cur_t_reg) - 33'(first_t_reg);

    always_comb begin
        cur_t_next   = cur_t_reg;
        prior_t_next = prior_t_reg;
        first_t_next = first_t_reg;
        open_next    = open_reg;
        seen_next    = seen_reg;
        integ_next   = integ_reg;
        stopped_next = stopped_reg;
        cnt_next     = cnt_reg;
        q_push       = 1'b0;
        q_data       = '0;
        if (s_valid && s_ready) begin
            case (s_mode)
                pnpt_pkg::MODE_TIME: begin
                    if (!stopped_reg) begin
                        if (s_frame_time >= $signed(cfg.end_time)) begin
                            stopped_next = 1'b1;
                        end else begin
                            prior_t_next = cur_t_reg;
                            cur_t_next   = s_frame_time;
                            integ_next   = seen_reg && (cur_t_reg >= $signed(cfg.start_time));
                            seen_next    = 1'b1;
                            if (!open_reg && (s_frame_time >= $signed(cfg.start_time))) begin
                                first_t_next = s_frame_time;
                                open_next    = 1'b1;
                            end
                            cnt_next = '0;
                        end
                    end
                end
                pnpt_pkg::MODE_SAMPLE: begin
                    if (!stopped_reg && below) begin
                        cnt_next = cnt_reg + 11'd1;
                        if (open_reg) begin
                            q_push         = 1'b1;
                            q_data.is_read = 1'b0;
                            q_data.addr    = MW'(cnt_reg);
                            q_data.sample  = s_sample_value;
                            q_data.integ   = integ_reg;
                            q_data.span    = 33'(cur_t_reg) - 33'(prior_t_reg);
                        end
                    end
                end
                pnpt_pkg::MODE_READ: begin
                    q_push         = 1'b1;
                    q_data.is_read = 1'b1;
                    q_data.addr    = MW'(s_read_node);
                    q_data.node    = s_read_node;
                    q_data.node_ok = int'(s_read_node) < NODES;
                    q_data.mean_ok = open_reg && (win_len != 33'sd0);
                    q_data.span    = win_len;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_t_reg   <= '0;
            prior_t_reg <= '0;
            first_t_reg <= '0;
            open_reg    <= 1'b0;
            seen_reg    <= 1'b0;
            integ_reg   <= 1'b0;
            stopped_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            cur_t_reg   <= cur_t_next;
            prior_t_reg <= prior_t_next;
            first_t_reg <= first_t_next;
            open_reg    <= open_next;
            seen_reg    <= seen_next;
            integ_reg   <= integ_next;
            stopped_reg <= stopped_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

// ===== src/pnpt_back.sv =====
`timescale 1ns / 1ps

module pnpt_back #(
    parameter int NODES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pnpt_pkg::cfg_t     cfg,
    input  logic               cmd_valid,
    input  pnpt_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    output logic               init_done,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_node,
    output logic signed [31:0] m_peak,
    output logic signed [31:0] m_mean,
    output logic signed [63:0] m_excess,
    output logic               m_mean_invalid
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

    localparam logic [2:0] MPH_IDLE = 3'd0;
    localparam logic [2:0] MPH_LO   = 3'd1;
    localparam logic [2:0] MPH_HI   = 3'd2;
    localparam logic [2:0] MPH_SUM  = 3'd3;
    localparam logic [2:0] MPH_SAT  = 3'd4;
    localparam logic [5:0] DIV_LAST = 6'd63;
    localparam logic [96:0] Q_NEG_LIM = 97'(1) << 63;
    localparam logic [96:0] Q_POS_LIM = Q_NEG_LIM - 97'(1);
    localparam logic [63:0] M_NEG_LIM = 64'(1) << 31;
    localparam logic [63:0] M_POS_LIM = M_NEG_LIM - 64'(1);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_TERM  = 9'b000001000,
        ST_POW   = 9'b000010000,
        ST_EXC   = 9'b000100000,
        ST_WRITE = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } back_state_t;

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? pnpt_pkg::S64_MIN : pnpt_pkg::S64_MAX;
        end
        return s[63:0];
    endfunction

    back_state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    pnpt_pkg::cmd_t cur_reg, cur_next;

    logic signed [31:0] peak_mem [NODES];
    logic signed [63:0] area_mem [NODES];
    logic signed [63:0] exc_mem  [NODES];
    logic signed [31:0] last_mem [NODES];
    logic signed [31:0] rd_peak, rd_last;
    logic signed [63:0] rd_area, rd_exc;
    logic               rd_en, we;
    logic [AW-1:0]      rd_addr, wr_addr;

    logic signed [31:0] mid_reg, mid_next;
    logic signed [32:0] d_reg, d_next;
    logic signed [32:0] mid_sum, d_now;
    logic signed [31:0] peak_w_reg, peak_w_next;
    logic signed [63:0] area_w_reg, area_w_next;
    logic signed [63:0] exc_w_reg, exc_w_next;
    logic signed [31:0] mean_w_reg, mean_w_next;
    logic               inv_reg, inv_next;
    logic [1:0]         pow_cnt_reg, pow_cnt_next;

    // shared multiplier, two partial products from the 32-bit halves of the first operand
    logic               mul_start;
    logic signed [63:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_sh;
    logic [2:0]         mph_reg;
    logic               mdone_reg;
    logic [63:0]        ma_reg;
    logic [32:0]        mb_reg;
    logic               mneg_reg, msh_reg;
    logic [64:0]        plo_reg, phi_reg;
    logic [96:0]        full_reg, q_shift, q_round;
    logic signed [63:0] mres_reg, mul_sat;

    // restoring divider, one quotient bit a cycle
    logic               div_start;
    logic               dbusy_reg, ddone_reg, dneg_reg;
    logic [5:0]         dcnt_reg;
    logic [63:0]        dq_reg;
    logic [32:0]        dr_reg, dv_reg;
    logic [33:0]        trial;
    logic               ge;
    logic signed [31:0] mean_sat;

    logic               out_load;

    assign init_done = (state_reg != ST_CLEAR);
    assign rd_en     = (state_reg == ST_IDLE) && cmd_valid;
    assign rd_addr   = AW'(cmd.addr);
    assign we        = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign wr_addr   = (state_reg == ST_CLEAR) ? clr_addr_reg : AW'(cur_reg.addr);
    assign mid_sum   = 33'(rd_last) + 33'($signed(cur_reg.sample));
    assign d_now     = 33'(mid_reg) - 33'($signed(cfg.threshold));
    assign out_load  = (state_reg == ST_OUT) && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_peak <= peak_mem[rd_addr];
            rd_area <= area_mem[rd_addr];
            rd_exc  <= exc_mem[rd_addr];
            rd_last <= last_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            if (state_reg == ST_CLEAR) begin
                peak_mem[wr_addr] <= pnpt_pkg::S32_MIN;
                area_mem[wr_addr] <= '0;
                exc_mem[wr_addr]  <= '0;
                last_mem[wr_addr] <= '0;
            end else begin
                peak_mem[wr_addr] <= peak_w_reg;
                area_mem[wr_addr] <= area_w_reg;
                exc_mem[wr_addr]  <= exc_w_reg;
                last_mem[wr_addr] <= cur_reg.sample;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cur_next      = cur_reg;
        mid_next      = mid_reg;
        d_next        = d_reg;
        peak_w_next   = peak_w_reg;
        area_w_next   = area_w_reg;
        exc_w_next    = exc_w_reg;
        mean_w_next   = mean_w_reg;
        inv_next      = inv_reg;
        pow_cnt_next  = pow_cnt_reg;
        cmd_pop       = 1'b0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        mul_sh        = 1'b0;
        div_start     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (cur_reg.is_read) begin
                    peak_w_next = cur_reg.node_ok ? rd_peak : pnpt_pkg::S32_MIN;
                    exc_w_next  = cur_reg.node_ok ? rd_exc : 64'sd0;
                    mean_w_next = '0;
                    inv_next    = 1'b1;
                    if (cur_reg.node_ok && cur_reg.mean_ok) begin
                        div_start  = 1'b1;
                        inv_next   = 1'b0;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else begin
                    peak_w_next = ($signed(cur_reg.sample) > rd_peak) ? cur_reg.sample : rd_peak;
                    area_w_next = rd_area;
                    exc_w_next  = rd_exc;
                    mid_next    = mid_sum[32:1];
                    if (cur_reg.integ) begin
                        mul_start  = 1'b1;
                        mul_a      = 64'($signed(cur_reg.span));
                        mul_b      = 33'($signed(mid_sum[32:1]));
                        state_next = ST_TERM;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_TERM: begin
                if (mdone_reg) begin
                    area_w_next = add_sat(area_w_reg, mres_reg);
                    state_next  = ST_WRITE;
                    if (!cfg.thr_enable) begin
                        exc_w_next = add_sat(exc_w_reg, mres_reg);
                    end else if ($signed(cur_reg.sample) > $signed(cfg.threshold)) begin
                        d_next    = d_now;
                        mul_start = 1'b1;
                        mul_a     = 64'(d_now);
                        case (cfg.exponent)
                            3'd0, 3'd1: begin
                                mul_b      = cur_reg.span;
                                state_next = ST_EXC;
                            end
                            3'd2: begin
                                mul_b        = d_now;
                                mul_sh       = 1'b1;
                                pow_cnt_next = 2'd0;
                                state_next   = ST_POW;
                            end
                            3'd3: begin
                                mul_b        = d_now;
                                mul_sh       = 1'b1;
                                pow_cnt_next = 2'd1;
                                state_next   = ST_POW;
                            end
                            default: begin
                                mul_b        = d_now;
                                mul_sh       = 1'b1;
                                pow_cnt_next = 2'd2;
                                state_next   = ST_POW;
                            end
                        endcase
                    end
                end
            end
            ST_POW: begin
                if (mdone_reg) begin
                    mul_start = 1'b1;
                    mul_a     = mres_reg;
                    if (pow_cnt_reg == 2'd0) begin
                        mul_b      = cur_reg.span;
                        state_next = ST_EXC;
                    end else begin
                        mul_b        = d_reg;
                        mul_sh       = 1'b1;
                        pow_cnt_next = pow_cnt_reg - 2'd1;
                    end
                end
            end
            ST_EXC: begin
                if (mdone_reg) begin
                    exc_w_next = add_sat(exc_w_reg, mres_reg);
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            ST_DIV: begin
                if (ddone_reg) begin
                    mean_w_next = mean_sat;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        mid_reg     <= mid_next;
        d_reg       <= d_next;
        peak_w_reg  <= peak_w_next;
        area_w_reg  <= area_w_next;
        exc_w_reg   <= exc_w_next;
        mean_w_reg  <= mean_w_next;
        inv_reg     <= inv_next;
        pow_cnt_reg <= pow_cnt_next;
    end

    // multiplier: floor of product over 2^16 when shifting, saturated to 64 bits
    always_comb begin
        q_shift = msh_reg ? (full_reg >> 16) : full_reg;
        q_round = q_shift + 97'(mneg_reg && msh_reg && (full_reg[15:0] != 16'd0));
        if (mneg_reg) begin
            mul_sat = (q_round > Q_NEG_LIM) ? pnpt_pkg::S64_MIN : -$signed(q_round[63:0]);
        end else begin
            mul_sat = (q_round > Q_POS_LIM) ? pnpt_pkg::S64_MAX : $signed(q_round[63:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mph_reg   <= MPH_IDLE;
            mdone_reg <= 1'b0;
        end else begin
            mdone_reg <= 1'b0;
            if (mul_start) begin
                mph_reg <= MPH_LO;
            end else begin
                case (mph_reg)
                    MPH_LO:  mph_reg <= MPH_HI;
                    MPH_HI:  mph_reg <= MPH_SUM;
                    MPH_SUM: mph_reg <= MPH_SAT;
                    MPH_SAT: begin
                        mph_reg   <= MPH_IDLE;
                        mdone_reg <= 1'b1;
                    end
                    default: mph_reg <= MPH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_start) begin
            ma_reg   <= mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
            mb_reg   <= mul_b[32] ? 33'(-mul_b) : 33'(mul_b);
            mneg_reg <= mul_a[63] ^ mul_b[32];
            msh_reg  <= mul_sh;
        end
        if (mph_reg == MPH_LO) begin
            plo_reg <= 65'(ma_reg[31:0]) * 65'(mb_reg);
        end
        if (mph_reg == MPH_HI) begin
            phi_reg <= 65'(ma_reg[63:32]) * 65'(mb_reg);
        end
        if (mph_reg == MPH_SUM) begin
            full_reg <= 97'(plo_reg) + (97'(phi_reg) << 32);
        end
        if (mph_reg == MPH_SAT) begin
            mres_reg <= mul_sat;
        end
    end

    // divider: magnitudes, truncation toward zero, saturated to 32 bits
    assign trial = {dr_reg, dq_reg[63]};
    assign ge    = (trial >= {1'b0, dv_reg});

    always_comb begin
        if (dneg_reg) begin
            mean_sat = (dq_reg > M_NEG_LIM) ? pnpt_pkg::S32_MIN : -$signed(dq_reg[31:0]);
        end else begin
            mean_sat = (dq_reg > M_POS_LIM) ? pnpt_pkg::S32_MAX : $signed(dq_reg[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else begin
            ddone_reg <= 1'b0;
            if (div_start) begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= '0;
            end else if (dbusy_reg) begin
                dcnt_reg <= dcnt_reg + 6'd1;
                if (dcnt_reg == DIV_LAST) begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            dq_reg   <= rd_area[63] ? 64'(-rd_area) : 64'(rd_area);
            dv_reg   <= cur_reg.span[32] ? 33'(-$signed(cur_reg.span)) : 33'(cur_reg.span);
            dr_reg   <= '0;
            dneg_reg <= rd_area[63] ^ cur_reg.span[32];
        end else if (dbusy_reg) begin
            dq_reg <= {dq_reg[62:0], ge};
            dr_reg <= ge ? 33'(trial - {1'b0, dv_reg}) : trial[32:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_node         <= cur_reg.node;
            m_peak         <= peak_w_reg;
            m_mean         <= mean_w_reg;
            m_excess       <= exc_w_reg;
            m_mean_invalid <= inv_reg;
        end
    end

endmodule

// ===== tb/per_node_peak_and_time_integral_tb.sv =====
`timescale 1ns / 1ps

module per_node_peak_and_time_integral_tb;

    localparam int NNODES = 1024;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] ftime;
        logic signed [31:0] sval;
        logic [9:0]         rnode;
        bit                 fixed;
        logic signed [31:0] pk;
        logic signed [31:0] mn;
        logic signed [63:0] ex;
        logic               inv;
    } item_t;

    typedef struct {
        logic [9:0]         node;
        logic signed [31:0] peak;
        logic signed [31:0] mean;
        logic signed [63:0] excess;
        logic               inv;
    } node_stats_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_mode;
    logic signed [31:0] s_frame_time;
    logic signed [31:0] s_sample_value;
    logic [9:0]         s_read_node;
    logic               m_valid;
    logic               m_ready;
    logic [9:0]         m_node;
    logic signed [31:0] m_peak;
    logic signed [31:0] m_mean;
    logic signed [63:0] m_excess;
    logic               m_mean_invalid;

    per_node_peak_and_time_integral DUT (.*);

    // model of the node stores and window
    logic signed [31:0] peak_mem [NNODES];
    logic signed [63:0] area_mem [NNODES];
    logic signed [63:0] excess_mem [NNODES];
    logic signed [31:0] last_mem [NNODES];
    longint             win_first, t_prior, t_cur;
    bit                 win_open, seen_frame, integ_ok, frozen;
    int unsigned        node_idx;

    logic signed [31:0] c_start, c_end, c_thr;
    logic               c_thr_en;
    logic [2:0]         c_exp;
    logic [10:0]        c_nodes;

    node_stats_t pending_stats[$];
    int          err_count = 0;
    int          results_seen = 0;
    bit          long_hold_done = 0;
    int          ready_hold = 0;
    int unsigned cyc = 0;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [63:0] mul_floor_sat(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh);
        logic signed [127:0] p;
        p = a * b;
        p = p >>> sh;
        if (p > pnpt_pkg::S64_MAX) return pnpt_pkg::S64_MAX;
        if (p < pnpt_pkg::S64_MIN) return pnpt_pkg::S64_MIN;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = a + b;
        if (s > pnpt_pkg::S64_MAX) return pnpt_pkg::S64_MAX;
        if (s < pnpt_pkg::S64_MIN) return pnpt_pkg::S64_MIN;
        return s[63:0];
    endfunction

    task automatic stats_reset();
        for (int i = 0; i < NNODES; i++) begin
            peak_mem[i] = pnpt_pkg::S32_MIN;
            area_mem[i] = 0;
            excess_mem[i] = 0;
            last_mem[i] = 0;
        end
        win_first = 0;
        t_prior = 0;
        t_cur = 0;
        win_open = 0;
        seen_frame = 0;
        integ_ok = 0;
        frozen = 0;
        node_idx = 0;
        c_start = pnpt_pkg::S32_MIN;
        c_end = pnpt_pkg::S32_MAX;
        c_thr_en = 0;
        c_thr = pnpt_pkg::S32_MIN;
        c_exp = 3'd1;
        c_nodes = 11'd1024;
    endtask

    function automatic node_stats_t read_stats(input logic [9:0] n);
        node_stats_t r;
        longint len, a, mq;
        r.node = n;
        r.peak = peak_mem[n];
        r.excess = excess_mem[n];
        r.mean = 0;
        r.inv = 1;
        len = t_cur - win_first;
        if (win_open && len != 0) begin
            a = area_mem[n];
            r.inv = 0;
            if (len == -1) mq = (a == pnpt_pkg::S64_MIN) ? pnpt_pkg::S64_MAX : -a;
            else mq = a / len;
            if (mq > longint'(pnpt_pkg::S32_MAX)) mq = pnpt_pkg::S32_MAX;
            if (mq < longint'(pnpt_pkg::S32_MIN)) mq = pnpt_pkg::S32_MIN;
            r.mean = mq[31:0];
        end
        return r;
    endfunction

    task automatic update_stats(input item_t it);
        int unsigned lim, i, e;
        longint dt, v, mid, d, p, term;
        node_stats_t r;
        case (it.mode)
            pnpt_pkg::MODE_TIME: begin
                if (!frozen) begin
                    if (longint'(it.ftime) >= longint'(c_end)) begin
                        frozen = 1;
                    end else begin
                        t_prior = t_cur;
                        t_cur = it.ftime;
                        integ_ok = seen_frame && (t_prior >= longint'(c_start));
                        seen_frame = 1;
                        if (!win_open && t_cur >= longint'(c_start)) begin
                            win_first = t_cur;
                            win_open = 1;
                        end
                        node_idx = 0;
                    end
                end
            end
            pnpt_pkg::MODE_SAMPLE: begin
                lim = (c_nodes < NNODES) ? c_nodes : NNODES;
                if (!frozen && node_idx < lim) begin
                    i = node_idx;
                    node_idx++;
                    if (win_open) begin
                        v = it.sval;
                        if (v > longint'(peak_mem[i])) peak_mem[i] = it.sval;
                        if (integ_ok) begin
                            dt = t_cur - t_prior;
                            mid = mul_floor_sat(longint'(last_mem[i]) + v, 1, 1);
                            term = mul_floor_sat(dt, mid, 0);
                            area_mem[i] = add_sat(area_mem[i], term);
                            if (!c_thr_en) begin
                                excess_mem[i] = add_sat(excess_mem[i], term);
                            end else if (v > longint'(c_thr)) begin
                                e = (c_exp == 0) ? 1 : ((c_exp > 4) ? 4 : c_exp);
                                d = mid - longint'(c_thr);
                                p = d;
                                for (int k = 1; k < e; k++) p = mul_floor_sat(p, d, 16);
                                excess_mem[i] = add_sat(excess_mem[i], mul_floor_sat(dt, p, 0));
                            end
                        end
                        last_mem[i] = it.sval;
                    end
                end
            end
            pnpt_pkg::MODE_READ: begin
                if (it.fixed) begin
                    r.node = it.rnode;
                    r.peak = it.pk;
                    r.mean = it.mn;
                    r.excess = it.ex;
                    r.inv = it.inv;
                end else begin
                    r = read_stats(it.rnode);
                end
                pending_stats.push_back(r);
            end
            default: ;
        endcase
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic offer(input item_t it);
        int g;
        s_valid <= 1'b1;
        s_mode <= it.mode;
        s_frame_time <= it.ftime;
        s_sample_value <= it.sval;
        s_read_node <= it.rnode;
        do @(posedge aclk); while (!s_ready);
        update_stats(it);
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic item_t mk(input logic [1:0] mode, input logic signed [31:0] ft,
                                 input logic signed [31:0] sv, input logic [9:0] n);
        item_t it;
        it.mode = mode;
        it.ftime = ft;
        it.sval = sv;
        it.rnode = n;
        it.fixed = 0;
        it.pk = 0;
        it.mn = 0;
        it.ex = 0;
        it.inv = 0;
        return it;
    endfunction

    function automatic item_t mk_reset_read(input logic [9:0] n);
        item_t it;
        it = mk(pnpt_pkg::MODE_READ, $urandom, $urandom, n);
        it.fixed = 1;
        it.pk = pnpt_pkg::S32_MIN;
        it.mn = 0;
        it.ex = 0;
        it.inv = 1;
        return it;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pnpt_pkg::REG_START_TIME: c_start = data;
            pnpt_pkg::REG_END_TIME:   c_end = data;
            pnpt_pkg::REG_THR_ENABLE: c_thr_en = data[0];
            pnpt_pkg::REG_THRESHOLD:  c_thr = data;
            pnpt_pkg::REG_EXPONENT:   c_exp = data[2:0];
            pnpt_pkg::REG_NODE_COUNT: c_nodes = data[10:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic set_phase(input logic signed [31:0] st, input logic signed [31:0] en,
                             input logic te, input logic signed [31:0] thr,
                             input logic [2:0] ex, input logic [10:0] nc);
        drain();
        write_reg(pnpt_pkg::REG_START_TIME, st);
        write_reg(pnpt_pkg::REG_END_TIME, en);
        write_reg(pnpt_pkg::REG_THR_ENABLE, {31'd0, te});
        write_reg(pnpt_pkg::REG_THRESHOLD, thr);
        write_reg(pnpt_pkg::REG_EXPONENT, {29'd0, ex});
        write_reg(pnpt_pkg::REG_NODE_COUNT, {21'd0, nc});
    endtask

    function automatic logic signed [31:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return pnpt_pkg::S32_MAX;
        if (r == 1) return pnpt_pkg::S32_MIN;
        if (r < 6) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        return $urandom;
    endfunction

    task automatic run_random(input int n_items, inout logic signed [31:0] t);
        int sent, r, cnt, lim;
        item_t it;
        sent = 0;
        lim = (c_nodes < 8) ? c_nodes : 8;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                offer(mk(pnpt_pkg::MODE_READ, $urandom, $urandom,
                         ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 9))));
                sent++;
            end else if (r < 15) begin
                offer(mk(MODE_NONE, $urandom, $urandom, 10'($urandom)));
                sent++;
            end else if (r < 18) begin
                offer(mk(pnpt_pkg::MODE_SAMPLE, $urandom, rand_sample(), 10'($urandom)));
                sent++;
            end else begin
                if (r < 21) t = $urandom;
                else if (r < 25) t = t - $urandom_range(0, 20);
                else t = t + $urandom_range(0, 40);
                if (t == pnpt_pkg::S32_MAX && c_end == pnpt_pkg::S32_MAX) t = t - 1;
                offer(mk(pnpt_pkg::MODE_TIME, t, $urandom, 10'($urandom)));
                sent++;
                cnt = $urandom_range(0, 9) == 0 ? $urandom_range(0, lim + 2) : lim;
                for (int k = 0; k < cnt; k++) begin
                    offer(mk(pnpt_pkg::MODE_SAMPLE, $urandom, rand_sample(), 10'($urandom)));
                    sent++;
                end
            end
        end
    endtask

    // receiver stalls, with one long hold-off
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!long_hold_done && results_seen == 30) begin
            long_hold_done <= 1;
            ready_hold <= 400;
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= (ready_hold == 1);
        end else if (cyc[8:7] == 2'd0) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            ready_hold <= gap_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge aclk) begin
        node_stats_t w;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_stats.size() == 0) begin
                report("unexpected transaction", {54'd0, m_node}, 64'd0);
            end else begin
                w = pending_stats.pop_front();
                if (m_node !== w.node) report("node", 64'(m_node), 64'(w.node));
                if (m_peak !== w.peak) report("peak", 64'(m_peak), 64'(w.peak));
                if (m_mean !== w.mean) report("mean", 64'(m_mean), 64'(w.mean));
                if (m_excess !== w.excess) report("excess", m_excess, w.excess);
                if (m_mean_invalid !== w.inv) begin
                    report("mean_invalid", 64'(m_mean_invalid), 64'(w.inv));
                end
            end
        end
    end

    item_t directed[$];

    initial begin
        logic signed [31:0] t;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_mode <= '0;
        s_frame_time <= '0;
        s_sample_value <= '0;
        s_read_node <= '0;
        m_ready <= 1'b0;
        stats_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part under reset settings
        directed.push_back(mk_reset_read(10'd0));
        directed.push_back(mk_reset_read(10'd1023));
        directed.push_back(mk(MODE_NONE, 32'h5555_5555, 32'hAAAA_AAAA, 10'h2AA));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, 7 << 16, 0));
        directed.push_back(mk(pnpt_pkg::MODE_TIME, 100, 0, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, pnpt_pkg::S32_MAX, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, pnpt_pkg::S32_MIN, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, 0, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, -1, 0));
        directed.push_back(mk(pnpt_pkg::MODE_TIME, 110, 0, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, pnpt_pkg::S32_MAX, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, pnpt_pkg::S32_MIN, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, 32'sh0001_0000, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, pnpt_pkg::S32_MIN, 0));
        directed.push_back(mk(pnpt_pkg::MODE_READ, 0, 0, 10'd0));
        directed.push_back(mk(pnpt_pkg::MODE_READ, 0, 0, 10'd1));
        directed.push_back(mk(pnpt_pkg::MODE_TIME, 110, 0, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, 32'sh0003_8000, 0));
        directed.push_back(mk(pnpt_pkg::MODE_TIME, 50, 0, 0));
        directed.push_back(mk(pnpt_pkg::MODE_SAMPLE, 0, pnpt_pkg::S32_MAX, 0));
        directed.push_back(mk(pnpt_pkg::MODE_READ, 0, 0, 10'd0));
        directed.push_back(mk(pnpt_pkg::MODE_READ, 0, 0, 10'd3));
        directed.push_back(mk(pnpt_pkg::MODE_READ, 0, 0, 10'd1023));
        directed.push_back(mk(pnpt_pkg::MODE_TIME, pnpt_pkg::S32_MIN, 0, 0));
        directed.push_back(mk(pnpt_pkg::MODE_READ, 0, 0, 10'd2));
        foreach (directed[i]) offer(directed[i]);

        t = 200;
        set_phase(0, pnpt_pkg::S32_MAX, 1'b1, 0, 3'd2, 11'd6);
        run_random(90, t);
        set_phase(pnpt_pkg::S32_MIN, pnpt_pkg::S32_MAX, 1'b1, pnpt_pkg::S32_MIN, 3'd4, 11'd5);
        run_random(80, t);
        set_phase(1000, pnpt_pkg::S32_MAX, 1'b1, pnpt_pkg::S32_MAX, 3'd0, 11'd3);
        t = 1000;
        run_random(70, t);
        set_phase(pnpt_pkg::S32_MAX, pnpt_pkg::S32_MAX, 1'b0, -65536, 3'd7, 11'd0);
        run_random(40, t);
        set_phase(-50, pnpt_pkg::S32_MAX, 1'b1, 32768, 3'd3, 11'd2047);
        offer(mk(pnpt_pkg::MODE_TIME, t + 1, 0, 0));
        for (int k = 0; k < 60; k++) offer(mk(pnpt_pkg::MODE_SAMPLE, 0, rand_sample(), 0));
        offer(mk(pnpt_pkg::MODE_READ, 0, 0, 10'd59));
        set_phase(0, 5000, 1'b1, $urandom, 3'd1, 11'd1);
        t = 0;
        run_random(100, t);
        offer(mk(pnpt_pkg::MODE_TIME, pnpt_pkg::S32_MAX, 0, 0));
        offer(mk(pnpt_pkg::MODE_SAMPLE, 0, pnpt_pkg::S32_MAX, 0));
        offer(mk(pnpt_pkg::MODE_TIME, 10, 0, 0));
        offer(mk(pnpt_pkg::MODE_READ, 0, 0, 10'd0));
        offer(mk(pnpt_pkg::MODE_READ, 0, 0, 10'd5));
        drain();

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pnpt_pkg.sv
src/pnpt_fifo.sv
src/pnpt_front.sv
src/pnpt_back.sv
src/per_node_peak_and_time_integral.sv
tb/per_node_peak_and_time_integral_tb.sv
